// File: rtl/obst_pkg.sv
`timescale 1ns / 1ps
package obst_pkg;
   localparam int MAX_KEYS = 32;
   localparam int IDX_W    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CNT_W    = $clog2(MAX_KEYS + 1);
   localparam int ADDR_W   = 2 * IDX_W;
   localparam int FREQ_W   = 16;
   localparam int COST_W   = 26;
   localparam int ACC_W    = COST_W + 2;
   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   typedef logic [FREQ_W-1:0] freq_type;
   typedef logic [COST_W-1:0] cost_type;
   typedef logic [ADDR_W-1:0] addr_type;
endpackage

// File: rtl/obst_cell.sv
`timescale 1ns / 1ps
module obst_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  obst_pkg::freq_type d_in,
   output obst_pkg::freq_type q
);
   import obst_pkg::*;

   freq_type freq_ff;

   // one key frequency, passed on to the next cell on each load
   always_ff @(posedge clock) begin
      if (shift_en) begin
         freq_ff <= d_in;
      end
   end

   assign q = freq_ff;
endmodule

// File: rtl/obst_cost_ram.sv
`timescale 1ns / 1ps
module obst_cost_ram (
   input  logic               clock,
   input  logic               wr_en,
   input  obst_pkg::addr_type wr_addr,
   input  obst_pkg::cost_type wr_data,
   input  obst_pkg::addr_type rd_addr_a,
   input  obst_pkg::addr_type rd_addr_b,
   output obst_pkg::cost_type rd_data_a,
   output obst_pkg::cost_type rd_data_b
);
   import obst_pkg::*;

   cost_type mem [2**ADDR_W];
   cost_type rd_a_ff;
   cost_type rd_b_ff;

   // interval cost table, one write and two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
endmodule

// File: rtl/optimal_bst_cost.sv
`timescale 1ns / 1ps
// Optimal binary search tree cost.
// Request channel: one key frequency per request (req_frequency), keys in sorted
// order, req_last_key marking the final key of a set. Up to MAX_KEYS keys are kept;
// further keys are dropped and flagged on the response (rsp_too_many_keys).
// Keys are loaded while the block is idle. After the final key the block stalls requests
// while it fills the interval cost table: first the single keys, then for each
// interval a setup step, one root trial per cycle through the two-port cost
// table, a drain step and a write back. The response then carries rsp_min_cost.
// A response waits in its output register while rsp_stall is high; the next set
// may be loaded and computed meanwhile, after which requests stay stalled until
// the waiting response is taken.
// Reset (synchronous, active high) clears the key count, overflow flag, the
// sequencer and the response valid; the tables are not cleared.
module optimal_bst_cost (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  obst_pkg::freq_type   req_frequency,
   input  logic                 req_last_key,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [25:0]          rsp_min_cost,
   output logic                 rsp_too_many_keys
);
   import obst_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIAG  = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_ROOT  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [IDX_W-1:0] root_ff, root_in;
   logic [IDX_W-1:0] hi;
   logic [ACC_W-1:0] sum_ff, sum_in;
   logic [ACC_W-1:0] min_ff, min_in;
   cost_type         last_wr_ff, last_wr_in;
   logic             s1_vld_ff;
   logic             s1_left_ff, s1_right_ff;
   freq_type         s1_freq_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   cost_type         rsp_cost_ff, rsp_cost_in;
   logic             rsp_tmk_ff, rsp_tmk_in;

   logic             accept;
   logic             shift_en;
   freq_type         cell_q [MAX_KEYS];
   freq_type         rd_freq;
   logic [IDX_W-1:0] rd_idx;
   logic             wr_en;
   addr_type         wr_addr, rd_addr_a, rd_addr_b;
   cost_type         wr_data, rd_data_a, rd_data_b;
   logic [ACC_W-1:0] trial, total;
   cost_type         total_sat;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign shift_en  = accept && (n_ff < CNT_W'(MAX_KEYS));

   // frequency chain: new key enters cell 0, key j sits in cell n-1-j
   genvar gi;
   generate
      for (gi = 0; gi < MAX_KEYS; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            obst_cell u_cell (
               .clock    (clock),
               .shift_en (shift_en),
               .d_in     (req_frequency),
               .q        (cell_q[gi])
            );
         end else begin : g_body
            obst_cell u_cell (
               .clock    (clock),
               .shift_en (shift_en),
               .d_in     (cell_q[gi-1]),
               .q        (cell_q[gi])
            );
         end
      end
   endgenerate

   assign hi = IDX_W'(lo_ff + IDX_W'(len_ff) - IDX_W'(1));

   // key lookup: diagonal fill reads key lo, root trials read key root
   always_comb begin
      if (state_ff == ST_DIAG) begin
         rd_idx = IDX_W'(n_ff - CNT_W'(1) - CNT_W'(lo_ff));
      end else begin
         rd_idx = IDX_W'(n_ff - CNT_W'(1) - CNT_W'(root_ff));
      end
   end
   assign rd_freq = cell_q[rd_idx];

   // table addresses: row is lo, column is hi
   assign rd_addr_a = {lo_ff, IDX_W'(root_ff - IDX_W'(1))};
   assign rd_addr_b = {IDX_W'(root_ff + IDX_W'(1)), hi};

   obst_cost_ram u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // left plus right cost of the trial leaving the table
   assign trial = (s1_left_ff  ? ACC_W'(rd_data_a) : ACC_W'(0))
                + (s1_right_ff ? ACC_W'(rd_data_b) : ACC_W'(0));
   assign total = sum_ff + min_ff;
   assign total_sat = (total > ACC_W'(COST_MAX)) ? COST_MAX : COST_W'(total);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {lo_ff, lo_ff};
      wr_data = COST_W'(rd_freq);
      if (state_ff == ST_DIAG) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_WRITE) begin
         wr_en   = 1'b1;
         wr_addr = {lo_ff, hi};
         wr_data = total_sat;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      ovf_in       = ovf_ff;
      len_in       = len_ff;
      lo_in        = lo_ff;
      root_in      = root_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      last_wr_in   = last_wr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cost_in  = rsp_cost_ff;
      rsp_tmk_in   = rsp_tmk_ff;

      if (s1_vld_ff) begin
         sum_in = sum_ff + ACC_W'(s1_freq_ff);
         if (trial < min_ff) begin
            min_in = trial;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (shift_en) begin
                  n_in = n_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_key) begin
                  lo_in    = '0;
                  state_in = ST_DIAG;
               end
            end
         end
         ST_DIAG: begin
            last_wr_in = wr_data;
            if (CNT_W'(lo_ff) == n_ff - CNT_W'(1)) begin
               lo_in  = '0;
               len_in = CNT_W'(2);
               state_in = (n_ff == CNT_W'(1)) ? ST_FIN : ST_SETUP;
            end else begin
               lo_in = lo_ff + IDX_W'(1);
            end
         end
         ST_SETUP: begin
            root_in  = lo_ff;
            sum_in   = '0;
            min_in   = '1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_ff == hi) begin
               state_in = ST_DRAIN;
            end else begin
               root_in = root_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            last_wr_in = total_sat;
            if ((CNT_W+1)'(lo_ff) + (CNT_W+1)'(len_ff) < (CNT_W+1)'(n_ff)) begin
               lo_in    = lo_ff + IDX_W'(1);
               state_in = ST_SETUP;
            end else if (len_ff == n_ff) begin
               state_in = ST_FIN;
            end else begin
               lo_in    = '0;
               len_in   = len_ff + CNT_W'(1);
               state_in = ST_SETUP;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_cost_in  = last_wr_ff;
               rsp_tmk_in   = ovf_ff;
               n_in         = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         n_ff         <= '0;
         ovf_ff       <= 1'b0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         ovf_ff       <= ovf_in;
         s1_vld_ff    <= (state_ff == ST_ROOT);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      lo_ff       <= lo_in;
      root_ff     <= root_in;
      sum_ff      <= sum_in;
      min_ff      <= min_in;
      last_wr_ff  <= last_wr_in;
      s1_left_ff  <= (root_ff != lo_ff);
      s1_right_ff <= (root_ff != hi);
      s1_freq_ff  <= rd_freq;
      rsp_cost_ff <= rsp_cost_in;
      rsp_tmk_ff  <= rsp_tmk_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_min_cost      = rsp_cost_ff;
   assign rsp_too_many_keys = rsp_tmk_ff;
endmodule
